[src/vfd_pkg.sv]
// Package for the frame voice decision block: types, constants, log table.
// No dependencies.
`timescale 1ns / 1ps
package vfd_pkg;
    localparam int RUN_BITS = 16;
    localparam int E_W = 23;
    localparam int NUM_W = E_W + RUN_BITS;
    localparam int DEN_W = RUN_BITS + 1;

    localparam logic [2:0] REG_GAIN = 3'd0;
    localparam logic [2:0] REG_FREQ = 3'd1;
    localparam logic [2:0] REG_FLAT = 3'd2;
    localparam logic [2:0] REG_PERIOD = 3'd3;
    localparam logic [2:0] REG_WINDOW = 3'd4;
    localparam logic [2:0] REG_SPH = 3'd5;
    localparam logic [2:0] REG_SIH = 3'd6;
    localparam logic [2:0] REG_VOTES = 3'd7;

    typedef struct packed {
        logic [15:0] energy_gain;
        logic [15:0] freq_threshold;
        logic [15:0] flatness_threshold;
        logic [15:0] frames_per_period;
        logic [7:0]  min_window;
        logic [7:0]  speech_hangover;
        logic [7:0]  silence_hangover;
        logic [1:0]  votes_needed;
    } cfg_t;

    // front -> back job
    typedef struct packed {
        logic [E_W-1:0] energy;
        logic [E_W-1:0] min_energy;
        logic           freq_vote;
        logic           flat_vote;
    } job_t;

    typedef struct packed {
        logic           is_speech;
        logic [1:0]     vote_count;
        logic [E_W-1:0] floor_energy;
    } res_t;

    function automatic logic [7:0] log2_frac(input logic [3:0] k);
        logic [7:0] r;
        case (k)
            4'd0: r = 8'd0;    4'd1: r = 8'd22;   4'd2: r = 8'd44;   4'd3: r = 8'd63;
            4'd4: r = 8'd82;   4'd5: r = 8'd100;  4'd6: r = 8'd118;  4'd7: r = 8'd134;
            4'd8: r = 8'd150;  4'd9: r = 8'd165;  4'd10: r = 8'd179; 4'd11: r = 8'd193;
            4'd12: r = 8'd207; 4'd13: r = 8'd220; 4'd14: r = 8'd232; default: r = 8'd244;
        endcase
        return r;
    endfunction
endpackage

[src/vfd_if.sv]
// Valid/ready stream interfaces for the frame inputs and the decision results.
// Depends on nothing.
`timescale 1ns / 1ps
interface vfd_in_if (input logic clk);
    logic        valid;
    logic        ready;
    logic [22:0] frame_energy;
    logic [15:0] dominant_hz;
    logic [15:0] flatness_db;
    modport source (output valid, frame_energy, dominant_hz, flatness_db, input ready);
    modport sink (input valid, frame_energy, dominant_hz, flatness_db, output ready);
endinterface

interface vfd_out_if (input logic clk);
    logic        valid;
    logic        ready;
    logic        is_speech;
    logic [1:0]  vote_count;
    logic [22:0] floor_energy;
    modport source (output valid, is_speech, vote_count, floor_energy, input ready);
    modport sink (input valid, is_speech, vote_count, floor_energy, output ready);
endinterface

[src/vfd_front.sv]
// Front part: frame counter, minima tracking, frequency and flatness votes.
// Depends on vfd_pkg.
`timescale 1ns / 1ps
module vfd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  vfd_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [22:0]       frame_energy,
    input  logic [15:0]       dominant_hz,
    input  logic [15:0]       flatness_db,
    output logic              job_valid,
    input  logic              job_ready,
    output vfd_pkg::job_t     job,
    input  logic              floor_valid,
    input  logic [22:0]       floor_value
);
    logic [15:0] frame_index_reg;
    logic [22:0] min_energy_reg;
    logic [15:0] min_freq_reg, min_flat_reg;
    logic        busy_reg;
    logic        job_valid_reg;
    vfd_pkg::job_t job_reg;

    logic [22:0] me;
    logic [15:0] mf, ms;
    logic [16:0] nxt;

    // one frame in flight: the back part writes the floor back before the next
    assign in_ready = !busy_reg;
    assign job_valid = job_valid_reg;
    assign job = job_reg;

    always_comb
    begin
        me = min_energy_reg;
        mf = min_freq_reg;
        ms = min_flat_reg;
        if (frame_index_reg == 16'd0)
        begin
            me = frame_energy;
            mf = dominant_hz;
            ms = flatness_db;
        end
        else if (frame_index_reg < {8'd0, cfg.min_window})
        begin
            if (frame_energy < me) me = frame_energy;
            if (dominant_hz < mf) mf = dominant_hz;
            if (flatness_db < ms) ms = flatness_db;
        end
        nxt = {1'b0, frame_index_reg} + 17'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_index_reg <= '0;
            min_energy_reg <= '0;
            min_freq_reg <= '0;
            min_flat_reg <= '0;
            busy_reg <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_valid_reg && job_ready)
                job_valid_reg <= 1'b0;
            if (in_valid && in_ready)
            begin
                min_energy_reg <= me;
                min_freq_reg <= mf;
                min_flat_reg <= ms;
                frame_index_reg <= (nxt >= {1'b0, cfg.frames_per_period}) ? 16'd0 : nxt[15:0];
                busy_reg <= 1'b1;
                job_valid_reg <= 1'b1;
                job_reg.energy <= frame_energy;
                job_reg.min_energy <= me;
                job_reg.freq_vote <= ({1'b0, dominant_hz} >= {1'b0, mf} + {1'b0, cfg.freq_threshold});
                job_reg.flat_vote <= ({1'b0, flatness_db} >= {1'b0, ms} + {1'b0, cfg.flatness_threshold});
            end
            if (floor_valid)
            begin
                min_energy_reg <= floor_value;
                busy_reg <= 1'b0;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) (in_valid && in_ready) |=> busy_reg);
    assert property (@(posedge clk) disable iff (!rst_n) floor_valid |-> busy_reg);
    assert property (@(posedge clk) disable iff (!rst_n) job_valid_reg |-> busy_reg);
endmodule

[src/vfd_back.sv]
// Back part: energy threshold via log table and multiply, runs, hangover,
// running-average floor through a serial divider in silence. Depends on vfd_pkg.
`timescale 1ns / 1ps
module vfd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  vfd_pkg::cfg_t     cfg,
    input  logic              job_valid,
    output logic              job_ready,
    input  vfd_pkg::job_t     job,
    output logic              floor_valid,
    output logic [22:0]       floor_value,
    output logic              res_valid,
    input  logic              res_ready,
    output vfd_pkg::res_t     res
);
    typedef enum logic [2:0] {S_IDLE, S_LOG, S_THR, S_DEC, S_DIV, S_OUT} state_t;
    localparam logic [vfd_pkg::RUN_BITS-1:0] RUN_MAX = '1;

    state_t state_reg;
    vfd_pkg::job_t job_reg;
    logic signed [15:0] l10_reg;
    logic signed [31:0] thr_reg;
    logic [1:0] votes_reg;
    logic [vfd_pkg::RUN_BITS-1:0] sp_run_reg, si_run_reg;
    logic decision_reg;
    logic [vfd_pkg::NUM_W-1:0] num_reg;
    logic [vfd_pkg::DEN_W-1:0] den_reg;
    logic [vfd_pkg::DEN_W:0] rem_reg;
    logic [5:0] cnt_reg;
    logic res_valid_reg, floor_valid_reg;
    vfd_pkg::res_t res_reg;

    // leading-one position and fraction bits
    logic [4:0] p;
    logic [3:0] k;
    logic signed [15:0] l2;
    logic signed [23:0] l77;
    logic signed [24:0] ediff;
    logic e_vote;
    logic [1:0] votes_sum;
    logic [vfd_pkg::RUN_BITS-1:0] sp_n, si_n;
    logic dec_n;
    logic [vfd_pkg::DEN_W:0] rem_sh;

    always_comb
    begin
        p = '0;
        for (int i = 0; i < 23; i++)
            if (job_reg.min_energy[i]) p = 5'(i);
        if (p >= 5'd4) k = 4'(job_reg.min_energy >> (p - 5'd4));
        else k = 4'(job_reg.min_energy << (5'd4 - p));
        l2 = (16'(signed'({1'b0, p})) - 16'sd8) * 16'sd256 + 16'(vfd_pkg::log2_frac(k));
        l77 = 24'(l2) * 24'sd77;
        ediff = 25'(signed'({2'b0, job_reg.energy})) - 25'(signed'({2'b0, job_reg.min_energy}));
        e_vote = (job_reg.min_energy == '0) || (32'(ediff) >= thr_reg);
        votes_sum = 2'(e_vote) + 2'(job_reg.freq_vote) + 2'(job_reg.flat_vote);
        sp_n = sp_run_reg;
        si_n = si_run_reg;
        if (votes_sum >= cfg.votes_needed)
        begin
            if (sp_run_reg != RUN_MAX) sp_n = sp_run_reg + 1'b1;
            si_n = '0;
        end
        else
        begin
            if (si_run_reg != RUN_MAX) si_n = si_run_reg + 1'b1;
            sp_n = '0;
        end
        dec_n = decision_reg;
        if (si_n > vfd_pkg::RUN_BITS'(cfg.silence_hangover)) dec_n = 1'b0;
        else if (sp_n > vfd_pkg::RUN_BITS'(cfg.speech_hangover)) dec_n = 1'b1;
        rem_sh = {rem_reg[vfd_pkg::DEN_W-1:0], num_reg[vfd_pkg::NUM_W-1]};
    end

    assign job_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res = res_reg;
    assign floor_valid = floor_valid_reg;
    assign floor_value = res_reg.floor_energy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_run_reg <= '0;
            si_run_reg <= '0;
            decision_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            floor_valid_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            // pulse the floor write-back with the result launch
            floor_valid_reg <= (state_reg == S_OUT) && !res_valid_reg;
            if (res_valid_reg && res_ready) res_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg <= job;
                        state_reg <= S_LOG;
                    end
                end
                S_LOG:
                begin
                    // truncate toward zero
                    l10_reg <= 16'((l77 < 0) ? -((-l77) >>> 8) : (l77 >>> 8));
                    state_reg <= S_THR;
                end
                S_THR:
                begin
                    thr_reg <= 32'(($signed({1'b0, cfg.energy_gain}) * 32'(l10_reg)) / 256);
                    state_reg <= S_DEC;
                end
                S_DEC:
                begin
                    votes_reg <= votes_sum;
                    sp_run_reg <= sp_n;
                    si_run_reg <= si_n;
                    decision_reg <= dec_n;
                    num_reg <= vfd_pkg::NUM_W'(si_n) * vfd_pkg::NUM_W'(job_reg.min_energy)
                               + vfd_pkg::NUM_W'(job_reg.energy);
                    den_reg <= vfd_pkg::DEN_W'(si_n) + 1'b1;
                    rem_reg <= '0;
                    cnt_reg <= '0;
                    state_reg <= dec_n ? S_OUT : S_DIV;
                end
                S_DIV:
                begin
                    // restoring division, one quotient bit a cycle
                    if (rem_sh >= {1'b0, den_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, den_reg};
                        num_reg <= {num_reg[vfd_pkg::NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        num_reg <= {num_reg[vfd_pkg::NUM_W-2:0], 1'b0};
                    end
                    if (cnt_reg == 6'(vfd_pkg::NUM_W - 1))
                        state_reg <= S_OUT;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_OUT:
                begin
                    // hold until the previous result has been taken
                    if (!res_valid_reg)
                    begin
                        res_reg.is_speech <= decision_reg;
                        res_reg.vote_count <= votes_reg;
                        res_reg.floor_energy <= decision_reg ? job_reg.min_energy
                                                             : num_reg[22:0];
                        res_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) floor_valid_reg |-> res_valid_reg);
    assert property (@(posedge clk) disable iff (!rst_n)
        (sp_run_reg == '0) || (si_run_reg == '0));
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEC) |=> (state_reg == S_DIV || state_reg == S_OUT));
endmodule

[src/vad_frame_decision.sv]
// Top level of the frame voice decision block.
// Depends on vfd_pkg, vfd_if, vfd_front, vfd_back.
`timescale 1ns / 1ps
// A speech frame's result skips the divider; a silence frame first passes the
// 39-bit serial divider for the running-average floor.
// One frame at a time: a new frame is taken only after the floor write-back of the last one.
// Reset: asynchronous active-low rst_n clears the control and run state and loads default registers.
module vad_frame_decision (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    vfd_in_if.sink      in_ch,
    vfd_out_if.source   out_ch
);
    vfd_pkg::cfg_t cfg_reg;
    vfd_pkg::job_t job;
    vfd_pkg::res_t res;
    logic job_valid, job_ready, floor_valid;
    logic [22:0] floor_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.energy_gain <= 16'd10240;
            cfg_reg.freq_threshold <= 16'd185;
            cfg_reg.flatness_threshold <= 16'd1280;
            cfg_reg.frames_per_period <= 16'd160;
            cfg_reg.min_window <= 8'd30;
            cfg_reg.speech_hangover <= 8'd4;
            cfg_reg.silence_hangover <= 8'd10;
            cfg_reg.votes_needed <= 2'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vfd_pkg::REG_GAIN:   cfg_reg.energy_gain <= cfg_data;
                vfd_pkg::REG_FREQ:   cfg_reg.freq_threshold <= cfg_data;
                vfd_pkg::REG_FLAT:   cfg_reg.flatness_threshold <= cfg_data;
                vfd_pkg::REG_PERIOD: cfg_reg.frames_per_period <= cfg_data;
                vfd_pkg::REG_WINDOW: cfg_reg.min_window <= cfg_data[7:0];
                vfd_pkg::REG_SPH:    cfg_reg.speech_hangover <= cfg_data[7:0];
                vfd_pkg::REG_SIH:    cfg_reg.silence_hangover <= cfg_data[7:0];
                vfd_pkg::REG_VOTES:  cfg_reg.votes_needed <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    vfd_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .frame_energy(in_ch.frame_energy), .dominant_hz(in_ch.dominant_hz),
        .flatness_db(in_ch.flatness_db),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .floor_valid(floor_valid), .floor_value(floor_value)
    );

    vfd_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .floor_valid(floor_valid), .floor_value(floor_value),
        .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(res)
    );

    assign out_ch.is_speech = res.is_speech;
    assign out_ch.vote_count = res.vote_count;
    assign out_ch.floor_energy = res.floor_energy;
endmodule
